>>> hw/rtl/rgb_shp_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// rgb_shp_pkg
// Shared types, constants and helpers of the RGB 3x3 sharpen filter.
// ============================================================================
package rgb_shp_pkg;

   localparam int MAX_WIDTH_DEFAULT = 1024;
   localparam int PIX_W             = 8;
   localparam int SUM_W             = 10;
   localparam int COL_OUT_W         = 10;
   localparam int ROW_W             = 12;
   localparam int FW_W              = 11;
   localparam int FH_W              = 12;
   localparam int MIN_SIZE          = 3;
   localparam int WINDOW_CELLS      = 2;
   localparam int QUEUE_DEPTH       = 4;
   localparam int QCNT_W            = 3;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 12;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 11'd500;
   localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 12'd281;

   typedef struct packed {
      logic [PIX_W-1:0] red_in;
      logic [PIX_W-1:0] green_in;
      logic [PIX_W-1:0] blue_in;
   } req_payload_type;

   typedef struct packed {
      logic [PIX_W-1:0]     red_out;
      logic [PIX_W-1:0]     green_out;
      logic [PIX_W-1:0]     blue_out;
      logic [COL_OUT_W-1:0] pixel_column;
      logic [ROW_W-1:0]     pixel_row;
      logic                 last_of_run;
   } rsp_payload_type;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      pixel_type upper;
      pixel_type middle;
      pixel_type lower;
   } column_type;

   typedef struct packed {
      pixel_type upper;
      pixel_type middle;
   } line_pair_type;

   typedef struct packed {
      logic [SUM_W-1:0] red;
      logic [SUM_W-1:0] green;
      logic [SUM_W-1:0] blue;
   } col_sum_type;

   typedef struct packed {
      logic [1:0]      count;
      rsp_payload_type first;
      rsp_payload_type second;
   } queue_push_type;

   function automatic col_sum_type column_sum(input column_type col);
      col_sum_type s;
      s.red   = SUM_W'(col.upper.red) + SUM_W'(col.middle.red) + SUM_W'(col.lower.red);
      s.green = SUM_W'(col.upper.green) + SUM_W'(col.middle.green)
              + SUM_W'(col.lower.green);
      s.blue  = SUM_W'(col.upper.blue) + SUM_W'(col.middle.blue) + SUM_W'(col.lower.blue);
      return s;
   endfunction

endpackage

>>> hw/rtl/rgb_sharpen_3x3_filter_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// rgb_sharpen_3x3_filter_unit
// Streaming 3x3 Laplacian sharpen of an RGB raster frame.
// ============================================================================
// A pixel is taken on every cycle in which the result queue has room, so while
// the result port does not stall a row's interior streams at one pixel per
// cycle; the last pixel of a row from the third row on and every pixel of the
// bottom row from the third column on give two results, and the single result
// port then sets the pace, with a four-entry result queue absorbing the bursts.
// A result passes through the input stage register and the result queue. The
// two line stores share one MAX_WIDTH x 48-bit RAM read once per pixel; results
// carry their own column and row and are not in raster order.
// ============================================================================
module rgb_sharpen_3x3_filter_unit #(
   parameter int MAX_WIDTH = rgb_shp_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  rgb_shp_pkg::req_payload_type           req_payload,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output rgb_shp_pkg::rsp_payload_type           rsp_payload,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [rgb_shp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rgb_shp_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int CNT_W  = $clog2(MAX_WIDTH);
   localparam int WIDE_W = (CNT_W + 1 > rgb_shp_pkg::FW_W) ? CNT_W + 1 : rgb_shp_pkg::FW_W;
   localparam int ROW_W  = rgb_shp_pkg::ROW_W;
   localparam int FH_W   = rgb_shp_pkg::FH_W;
   localparam int NCELL  = rgb_shp_pkg::WINDOW_CELLS;

   function automatic logic [7:0] sharpen(input logic [7:0] center,
                                          input logic [9:0] s0,
                                          input logic [9:0] s1,
                                          input logic [9:0] s2);
      logic [11:0]        ten_c;
      logic [11:0]        total;
      logic signed [12:0] acc;
      ten_c = {1'b0, center, 3'b000} + {3'b000, center, 1'b0};
      total = 12'(s0) + 12'(s1) + 12'(s2);
      acc   = $signed({1'b0, ten_c}) - $signed({1'b0, total});
      priority if (acc < 13'sd0) begin
         return 8'd0;
      end else if (acc > 13'sd255) begin
         return 8'd255;
      end else begin
         return acc[7:0];
      end
   endfunction

   logic [rgb_shp_pkg::FW_W-1:0] frame_width_ff;
   logic [FH_W-1:0]              frame_height_ff;
   logic [WIDE_W-1:0]            w_eff;
   logic [FH_W-1:0]              h_eff;

   logic [CNT_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [WIDE_W-1:0] col_plus;
   logic [ROW_W:0]    row_plus;
   logic              emit_int, emit_edge;
   logic              accept;

   logic                   s1_valid_ff;
   rgb_shp_pkg::pixel_type s1_cur_ff;
   logic [CNT_W-1:0]       s1_col_ff;
   logic [ROW_W-1:0]       s1_row_ff;
   logic                   s1_int_ff, s1_edge_ff;
   logic                   s1_go;
   logic                   q_room;

   rgb_shp_pkg::pixel_type      cur_pix;
   rgb_shp_pkg::line_pair_type  ram_rd, ram_wr;
   logic [47:0]                 ram_rd_raw;
   rgb_shp_pkg::column_type     win_col [NCELL + 1];
   rgb_shp_pkg::col_sum_type    win_sum [NCELL + 1];
   rgb_shp_pkg::pixel_type      sharp_pix;
   rgb_shp_pkg::rsp_payload_type res_int, res_edge;
   rgb_shp_pkg::queue_push_type push;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= rgb_shp_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= rgb_shp_pkg::FRAME_HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            rgb_shp_pkg::CSR_FRAME_WIDTH: begin
               frame_width_ff <= csr_wdata[rgb_shp_pkg::FW_W-1:0];
            end
            rgb_shp_pkg::CSR_FRAME_HEIGHT: begin
               frame_height_ff <= csr_wdata[FH_W-1:0];
            end
         endcase
      end
   end

   always_comb begin
      priority if (WIDE_W'(frame_width_ff) < WIDE_W'(rgb_shp_pkg::MIN_SIZE)) begin
         w_eff = WIDE_W'(rgb_shp_pkg::MIN_SIZE);
      end else if (WIDE_W'(frame_width_ff) > WIDE_W'(MAX_WIDTH)) begin
         w_eff = WIDE_W'(MAX_WIDTH);
      end else begin
         w_eff = WIDE_W'(frame_width_ff);
      end
      if (frame_height_ff < FH_W'(rgb_shp_pkg::MIN_SIZE)) begin
         h_eff = FH_W'(rgb_shp_pkg::MIN_SIZE);
      end else begin
         h_eff = frame_height_ff;
      end
   end

   // input stage: counters and emit decisions
   assign req_stall = s1_valid_ff && !q_room;
   assign accept    = req_valid && !req_stall;
   assign s1_go     = s1_valid_ff && q_room;

   always_comb begin
      col_plus  = WIDE_W'(col_ff) + WIDE_W'(1);
      row_plus  = (ROW_W + 1)'(row_ff) + (ROW_W + 1)'(1);
      emit_int  = (col_ff >= CNT_W'(2)) && (row_ff >= ROW_W'(2))
                && (WIDE_W'(col_ff) < w_eff) && (row_ff < h_eff);
      emit_edge = (row_ff == '0) || (col_ff == '0) || (col_plus >= w_eff)
                || (row_plus >= (ROW_W + 1)'(h_eff));
      if (col_plus >= w_eff) begin
         col_in = '0;
         if (row_plus >= (ROW_W + 1)'(h_eff)) begin
            row_in = '0;
         end else begin
            row_in = row_plus[ROW_W-1:0];
         end
      end else begin
         col_in = col_plus[CNT_W-1:0];
         row_in = row_ff;
      end
   end

   assign cur_pix.red   = req_payload.red_in;
   assign cur_pix.green = req_payload.green_in;
   assign cur_pix.blue  = req_payload.blue_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_go) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cur_ff  <= cur_pix;
         s1_col_ff  <= col_ff;
         s1_row_ff  <= row_ff;
         s1_int_ff  <= emit_int;
         s1_edge_ff <= emit_edge;
      end
   end

   // line stores: read on accept, write back as the item leaves
   assign ram_wr.upper  = ram_rd.middle;
   assign ram_wr.middle = s1_cur_ff;
   assign ram_rd        = rgb_shp_pkg::line_pair_type'(ram_rd_raw);

   rgb_shp_ram #(
      .WIDTH ($bits(rgb_shp_pkg::line_pair_type)),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_go),
      .wr_addr (s1_col_ff),
      .wr_data (ram_wr),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (ram_rd_raw)
   );

   // window: chain of column cells
   assign win_col[0].upper  = ram_rd.upper;
   assign win_col[0].middle = ram_rd.middle;
   assign win_col[0].lower  = s1_cur_ff;
   assign win_sum[0]        = rgb_shp_pkg::column_sum(win_col[0]);

   for (genvar g = 0; g < NCELL; g++) begin : g_cell
      rgb_shp_col_cell u_cell (
         .clock    (clock),
         .shift_en (s1_go),
         .col_in   (win_col[g]),
         .col_out  (win_col[g + 1]),
         .sum_out  (win_sum[g + 1])
      );
   end

   assign sharp_pix.red   = sharpen(win_col[1].middle.red, win_sum[0].red,
                                    win_sum[1].red, win_sum[2].red);
   assign sharp_pix.green = sharpen(win_col[1].middle.green, win_sum[0].green,
                                    win_sum[1].green, win_sum[2].green);
   assign sharp_pix.blue  = sharpen(win_col[1].middle.blue, win_sum[0].blue,
                                    win_sum[1].blue, win_sum[2].blue);

   // results
   always_comb begin
      res_int.red_out       = sharp_pix.red;
      res_int.green_out     = sharp_pix.green;
      res_int.blue_out      = sharp_pix.blue;
      res_int.pixel_column  = rgb_shp_pkg::COL_OUT_W'(CNT_W'(s1_col_ff - CNT_W'(1)));
      res_int.pixel_row     = s1_row_ff - ROW_W'(1);
      res_int.last_of_run   = !s1_edge_ff;

      res_edge.red_out      = s1_cur_ff.red;
      res_edge.green_out    = s1_cur_ff.green;
      res_edge.blue_out     = s1_cur_ff.blue;
      res_edge.pixel_column = rgb_shp_pkg::COL_OUT_W'(s1_col_ff);
      res_edge.pixel_row    = s1_row_ff;
      res_edge.last_of_run  = 1'b1;

      push.first  = s1_int_ff ? res_int : res_edge;
      push.second = res_edge;
      if (!s1_go) begin
         push.count = 2'd0;
      end else begin
         push.count = 2'(s1_int_ff) + 2'(s1_edge_ff);
      end
   end

   rgb_shp_out_queue u_out_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .room        (q_room),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   a_hold_item: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_go) |=> (s1_valid_ff && $stable(s1_col_ff) && $stable(s1_row_ff)))
      else $error("pending transaction lost while held");

   a_col_bound: assert property (@(posedge clock) disable iff (reset)
      WIDE_W'(col_ff) < WIDE_W'(MAX_WIDTH))
      else $error("column counter beyond line store depth");

   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      row_ff != '1)
      else $error("row counter out of range");

endmodule

>>> hw/rtl/rgb_shp_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// rgb_shp_ram
// Generic single-write, single-read RAM with registered, enabled read.
// ============================================================================
module rgb_shp_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/rgb_shp_col_cell.sv
`timescale 1ns / 1ps
// ============================================================================
// rgb_shp_col_cell
// One window column cell: holds a three-pixel column and its channel sums,
// and hands both to the next cell on every shift.
// ============================================================================
module rgb_shp_col_cell (
   input  logic                     clock,
   input  logic                     shift_en,
   input  rgb_shp_pkg::column_type  col_in,
   output rgb_shp_pkg::column_type  col_out,
   output rgb_shp_pkg::col_sum_type sum_out
);

   rgb_shp_pkg::column_type  col_ff;
   rgb_shp_pkg::col_sum_type sum_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         col_ff <= col_in;
         sum_ff <= rgb_shp_pkg::column_sum(col_in);
      end
   end

   assign col_out = col_ff;
   assign sum_out = sum_ff;

endmodule

>>> hw/rtl/rgb_shp_out_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// rgb_shp_out_queue
// Shifting result queue: takes up to two results per cycle, issues one
// transaction per cycle on the result channel while it is not stalled.
// ============================================================================
module rgb_shp_out_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  rgb_shp_pkg::queue_push_type  push,
   output logic                         room,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output rgb_shp_pkg::rsp_payload_type rsp_payload
);

   localparam int QW = rgb_shp_pkg::QCNT_W;
   localparam int QD = rgb_shp_pkg::QUEUE_DEPTH;

   rgb_shp_pkg::rsp_payload_type q_ff [QD];
   rgb_shp_pkg::rsp_payload_type q_in [QD];
   logic [QW-1:0] count_ff;
   logic [QW-1:0] count_in;
   logic [QW-1:0] base;
   logic          pop;

   always_comb begin
      pop  = (count_ff != '0) && !rsp_stall;
      base = count_ff - QW'(pop);
      for (int i = 0; i < QD; i++) begin
         if (QW'(i) < base) begin
            q_in[i] = pop ? q_ff[(i + 1) % QD] : q_ff[i];
         end else if ((QW'(i) == base) && (push.count != 2'd0)) begin
            q_in[i] = push.first;
         end else if ((QW'(i) == QW'(base + QW'(1))) && (push.count == 2'd2)) begin
            q_in[i] = push.second;
         end else begin
            q_in[i] = q_ff[i];
         end
      end
      count_in = base + QW'(push.count);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QD; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

   assign room        = count_ff <= QW'(QD - 2);
   assign rsp_valid   = count_ff != '0;
   assign rsp_payload = q_ff[0];

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QW'(QD))
      else $error("result queue count beyond depth");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> (count_ff <= QW'(QD - 2)))
      else $error("results pushed without room");

endmodule
